/* rtl/request_fingerprint_dedup_table_defines.svh */
// ============================================================================
// Dedup table assertion macros
// Shared concurrent assertion forms for the dedup table RTL.
// ============================================================================
`ifndef REQUEST_FINGERPRINT_DEDUP_TABLE_DEFINES_SVH
`define REQUEST_FINGERPRINT_DEDUP_TABLE_DEFINES_SVH

// implication checked on every clock, off during reset
`define RFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked on every clock, off during reset
`define RFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rfd_pkg.sv */
// ============================================================================
// Dedup table package
// Shared constants and control types for the request dedup table.
// ============================================================================
`default_nettype none
package rfd_pkg;
   localparam int HistDepthDefault  = 8;
   localparam int EvictDepthDefault = 8;

   localparam logic [2:0] CMD_INSPECT     = 3'd0;
   localparam logic [2:0] CMD_RECORD      = 3'd1;
   localparam logic [2:0] CMD_CLEAR       = 3'd2;
   localparam logic [2:0] CMD_RESOLVE     = 3'd3;
   localparam logic [2:0] CMD_RESOLVE_DUP = 3'd4;

   localparam logic [1:0] VERDICT_NEW       = 2'd0;
   localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
   localparam logic [1:0] VERDICT_CONFLICT  = 2'd2;

   localparam logic [1:0] CSR_BUSY_CODE       = 2'd0;
   localparam logic [1:0] CSR_INCOMPLETE_CODE = 2'd1;
   localparam logic [1:0] CSR_RETRYABLE_MASK  = 2'd2;
   localparam logic [1:0] CSR_DUPLICATE_MASK  = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic capture;  // latch request, run compare
      logic execute;  // apply command, drive result
   } ctrl_type;
endpackage
`default_nettype wire

/* rtl/request_fingerprint_dedup_table.sv */
// ============================================================================
// Request fingerprint dedup table
// Start captures the request; the execute state applies it and registers result and strobe.
// Busy is high in the cycle after the transfer; no new command is taken while busy.
// Reset (synchronous, active high) empties both rings and zeroes pointers and configuration.
// ============================================================================
`default_nettype none
module request_fingerprint_dedup_table #(
   parameter int HISTORY_DEPTH = rfd_pkg::HistDepthDefault,
   parameter int EVICT_DEPTH   = rfd_pkg::EvictDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   input  wire logic [2:0]  req_command,
   input  wire logic [31:0] req_request_id,
   input  wire logic [31:0] req_frame_id,
   input  wire logic [31:0] req_session_id,
   input  wire logic [31:0] req_payload_crc,
   input  wire logic [15:0] req_packet_index,
   input  wire logic [15:0] req_packet_count,
   input  wire logic [7:0]  req_message_type,
   input  wire logic [1:0]  req_logical_flags,
   input  wire logic [2:0]  req_entry_index,
   input  wire logic [7:0]  req_result_code,
   input  wire logic [7:0]  req_result_flags,
   output logic             rsp_valid,
   output logic [1:0]       rsp_verdict,
   output logic             rsp_has_entry,
   output logic [2:0]       rsp_found_index,
   output logic             rsp_has_cached,
   output logic [7:0]       rsp_out_code,
   output logic [7:0]       rsp_out_flags
);
   rfd_pkg::ctrl_type ctrl;

   rfd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .ctrl(ctrl)
   );

   rfd_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .EVICT_DEPTH(EVICT_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_command(req_command), .req_request_id(req_request_id),
      .req_frame_id(req_frame_id), .req_session_id(req_session_id),
      .req_payload_crc(req_payload_crc), .req_packet_index(req_packet_index),
      .req_packet_count(req_packet_count), .req_message_type(req_message_type),
      .req_logical_flags(req_logical_flags), .req_entry_index(req_entry_index),
      .req_result_code(req_result_code), .req_result_flags(req_result_flags),
      .rsp_valid(rsp_valid), .rsp_verdict(rsp_verdict), .rsp_has_entry(rsp_has_entry),
      .rsp_found_index(rsp_found_index), .rsp_has_cached(rsp_has_cached),
      .rsp_out_code(rsp_out_code), .rsp_out_flags(rsp_out_flags)
   );
endmodule
`default_nettype wire

/* rtl/rfd_ctrl.sv */
// ============================================================================
// Dedup table controller
// Two-step sequencer: capture and compare, then update and respond.
// ============================================================================
`default_nettype none
`include "request_fingerprint_dedup_table_defines.svh"
module rfd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output rfd_pkg::ctrl_type     ctrl
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy         = (state_ff == ST_EXEC);
   assign ctrl.capture = start && (state_ff == ST_IDLE);
   assign ctrl.execute = (state_ff == ST_EXEC);

   `RFD_ASSERT_NEXT(a_cap_then_exec, clock, reset, ctrl.capture, ctrl.execute, "capture not followed by execute")
   `RFD_ASSERT_NEXT(a_exec_then_idle, clock, reset, ctrl.execute, !ctrl.execute, "execute lasted two cycles")
   `RFD_ASSERT_IMP(a_no_overlap, clock, reset, ctrl.execute, !ctrl.capture, "capture during execute")
endmodule
`default_nettype wire

/* rtl/rfd_datapath.sv */
// ============================================================================
// Dedup table datapath
// History and eviction rings, parallel id compare, cache update, result regs.
// ============================================================================
`default_nettype none
`include "request_fingerprint_dedup_table_defines.svh"
module rfd_datapath #(
   parameter int HISTORY_DEPTH = rfd_pkg::HistDepthDefault,
   parameter int EVICT_DEPTH   = rfd_pkg::EvictDepthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rfd_pkg::ctrl_type ctrl,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data,
   input  wire logic [2:0]        req_command,
   input  wire logic [31:0]       req_request_id,
   input  wire logic [31:0]       req_frame_id,
   input  wire logic [31:0]       req_session_id,
   input  wire logic [31:0]       req_payload_crc,
   input  wire logic [15:0]       req_packet_index,
   input  wire logic [15:0]       req_packet_count,
   input  wire logic [7:0]        req_message_type,
   input  wire logic [1:0]        req_logical_flags,
   input  wire logic [2:0]        req_entry_index,
   input  wire logic [7:0]        req_result_code,
   input  wire logic [7:0]        req_result_flags,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_verdict,
   output logic                   rsp_has_entry,
   output logic [2:0]             rsp_found_index,
   output logic                   rsp_has_cached,
   output logic [7:0]             rsp_out_code,
   output logic [7:0]             rsp_out_flags
);
   localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int EW = (EVICT_DEPTH > 1) ? $clog2(EVICT_DEPTH) : 1;

   // configuration
   logic [7:0] busy_code_ff, incomplete_code_ff, retryable_mask_ff, duplicate_mask_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_code_ff       <= '0;
         incomplete_code_ff <= '0;
         retryable_mask_ff  <= '0;
         duplicate_mask_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            rfd_pkg::CSR_BUSY_CODE:       busy_code_ff       <= csr_data;
            rfd_pkg::CSR_INCOMPLETE_CODE: incomplete_code_ff <= csr_data;
            rfd_pkg::CSR_RETRYABLE_MASK:  retryable_mask_ff  <= csr_data;
            rfd_pkg::CSR_DUPLICATE_MASK:  duplicate_mask_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ring storage; payload arrays need no reset since occupancy gates reads
   logic [31:0] h_req_ff [HISTORY_DEPTH];
   logic [31:0] h_frm_ff [HISTORY_DEPTH];
   logic [31:0] h_ses_ff [HISTORY_DEPTH];
   logic [31:0] h_crc_ff [HISTORY_DEPTH];
   logic [15:0] h_idx_ff [HISTORY_DEPTH];
   logic [15:0] h_cnt_ff [HISTORY_DEPTH];
   logic [7:0]  h_typ_ff [HISTORY_DEPTH];
   logic [1:0]  h_flg_ff [HISTORY_DEPTH];
   logic [7:0]  h_ccode_ff [HISTORY_DEPTH];
   logic [7:0]  h_cflags_ff [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] h_cached_ff, h_occ_ff;
   logic [31:0] e_req_ff [EVICT_DEPTH];
   logic [EVICT_DEPTH-1:0] e_occ_ff;
   logic [HW-1:0] h_next_ff;
   logic [EW-1:0] e_next_ff;

   // captured request
   logic [2:0]  cmd_ff;
   logic [31:0] rid_ff, fid_ff, sid_ff, crc_ff;
   logic [15:0] pidx_ff, pcnt_ff;
   logic [7:0]  mtype_ff, rcode_ff, rflags_ff;
   logic [1:0]  lflags_ff;
   logic [2:0]  eidx_ff;
   // compare results registered in the capture cycle
   logic [HISTORY_DEPTH-1:0] hit_ff, same_ff;
   logic [EVICT_DEPTH-1:0]   ehit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff    <= req_command;
         rid_ff    <= req_request_id;
         fid_ff    <= req_frame_id;
         sid_ff    <= req_session_id;
         crc_ff    <= req_payload_crc;
         pidx_ff   <= req_packet_index;
         pcnt_ff   <= req_packet_count;
         mtype_ff  <= req_message_type;
         lflags_ff <= req_logical_flags;
         eidx_ff   <= req_entry_index;
         rcode_ff  <= req_result_code;
         rflags_ff <= req_result_flags;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hit_ff[i]  <= h_occ_ff[i] && (h_req_ff[i] == req_request_id);
            same_ff[i] <= (h_frm_ff[i] == req_frame_id) && (h_ses_ff[i] == req_session_id)
                       && (h_crc_ff[i] == req_payload_crc)
                       && (h_idx_ff[i] == req_packet_index)
                       && (h_cnt_ff[i] == req_packet_count)
                       && (h_typ_ff[i] == req_message_type)
                       && (h_flg_ff[i] == req_logical_flags);
         end
         for (int i = 0; i < EVICT_DEPTH; i++)
            ehit_ff[i] <= e_occ_ff[i] && (e_req_ff[i] == req_request_id);
      end
   end

   // lowest-index hit
   logic          any_hit;
   logic [HW-1:0] hit_idx;
   always_comb begin
      any_hit = 1'b0;
      hit_idx = '0;
      for (int i = HISTORY_DEPTH - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            any_hit = 1'b1;
            hit_idx = HW'(i);
         end
      end
   end

   // resolve index in range?
   logic          res_ok;
   logic [HW-1:0] res_idx;
   always_comb begin
      res_ok  = ({29'd0, eidx_ff} < HISTORY_DEPTH);
      res_idx = HW'(eidx_ff);
   end

   logic transient;
   assign transient = (rcode_ff == busy_code_ff) || (rcode_ff == incomplete_code_ff)
                   || ((rflags_ff & retryable_mask_ff) != 8'd0);

   logic is_inspect, is_resolve, dup_ret, do_record, victim;
   assign is_inspect = (cmd_ff == rfd_pkg::CMD_INSPECT) || (cmd_ff == rfd_pkg::CMD_RECORD);
   assign is_resolve = (cmd_ff == rfd_pkg::CMD_RESOLVE) || (cmd_ff == rfd_pkg::CMD_RESOLVE_DUP);
   assign dup_ret    = (cmd_ff == rfd_pkg::CMD_RESOLVE_DUP) && res_ok && h_cached_ff[res_idx];
   assign do_record  = ctrl.execute && (cmd_ff == rfd_pkg::CMD_RECORD) && !any_hit
                    && (ehit_ff == '0);
   assign victim     = h_occ_ff[h_next_ff];

   // ring update
   always_ff @(posedge clock) begin
      if (do_record) begin
         h_req_ff[h_next_ff] <= rid_ff;
         h_frm_ff[h_next_ff] <= fid_ff;
         h_ses_ff[h_next_ff] <= sid_ff;
         h_crc_ff[h_next_ff] <= crc_ff;
         h_idx_ff[h_next_ff] <= pidx_ff;
         h_cnt_ff[h_next_ff] <= pcnt_ff;
         h_typ_ff[h_next_ff] <= mtype_ff;
         h_flg_ff[h_next_ff] <= lflags_ff;
         if (victim) e_req_ff[e_next_ff] <= h_req_ff[h_next_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.execute && cmd_ff == rfd_pkg::CMD_CLEAR)) begin
         h_occ_ff    <= '0;
         h_cached_ff <= '0;
         e_occ_ff    <= '0;
         h_next_ff   <= '0;
         e_next_ff   <= '0;
      end else if (do_record) begin
         h_occ_ff[h_next_ff]    <= 1'b1;
         h_cached_ff[h_next_ff] <= 1'b0;
         h_next_ff <= (32'(h_next_ff) == HISTORY_DEPTH - 1) ? '0 : h_next_ff + 1'b1;
         if (victim) begin
            e_occ_ff[e_next_ff] <= 1'b1;
            e_next_ff <= (32'(e_next_ff) == EVICT_DEPTH - 1) ? '0 : e_next_ff + 1'b1;
         end
      end else if (ctrl.execute && is_resolve && res_ok && !dup_ret && !transient) begin
         h_cached_ff[res_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.execute && is_resolve && res_ok && !dup_ret && !transient) begin
         h_ccode_ff[res_idx]  <= rcode_ff;
         h_cflags_ff[res_idx] <= rflags_ff;
      end
   end

   // result register
   logic [1:0] verdict_in;
   logic       has_entry_in, has_cached_in;
   logic [2:0] found_in;
   logic [7:0] code_in, flags_in;
   always_comb begin
      verdict_in    = rfd_pkg::VERDICT_NEW;
      has_entry_in  = 1'b0;
      found_in      = '0;
      has_cached_in = 1'b0;
      code_in       = '0;
      flags_in      = '0;
      if (is_inspect) begin
         if (any_hit) begin
            verdict_in    = same_ff[hit_idx] ? rfd_pkg::VERDICT_DUPLICATE
                                             : rfd_pkg::VERDICT_CONFLICT;
            has_entry_in  = 1'b1;
            found_in      = 3'(hit_idx);
            has_cached_in = h_cached_ff[hit_idx];
            code_in       = h_cached_ff[hit_idx] ? h_ccode_ff[hit_idx] : 8'd0;
            flags_in      = h_cached_ff[hit_idx] ? h_cflags_ff[hit_idx] : 8'd0;
         end else if (ehit_ff != '0) begin
            verdict_in = rfd_pkg::VERDICT_CONFLICT;
         end else if (do_record) begin
            has_entry_in = 1'b1;
            found_in     = 3'(h_next_ff);
         end
      end else if (is_resolve) begin
         if (!res_ok) begin
            code_in  = rcode_ff;
            flags_in = rflags_ff;
         end else begin
            has_entry_in = 1'b1;
            found_in     = eidx_ff;
            if (dup_ret) begin
               verdict_in    = rfd_pkg::VERDICT_DUPLICATE;
               has_cached_in = 1'b1;
               code_in       = h_ccode_ff[res_idx];
               flags_in      = h_cflags_ff[res_idx] | duplicate_mask_ff;
            end else begin
               has_cached_in = h_cached_ff[res_idx] || !transient;
               code_in       = rcode_ff;
               flags_in      = rflags_ff;
            end
         end
      end
   end

   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= ctrl.execute;
   end
   always_ff @(posedge clock) begin
      if (ctrl.execute) begin
         rsp_verdict     <= verdict_in;
         rsp_has_entry   <= has_entry_in;
         rsp_found_index <= found_in;
         rsp_has_cached  <= has_cached_in;
         rsp_out_code    <= code_in;
         rsp_out_flags   <= flags_in;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   `RFD_ASSERT_NEXT(a_valid_follows, clock, reset, ctrl.execute, rsp_valid, "missing result strobe")
   `RFD_ASSERT_NEXT(a_no_evict_without_victim, clock, reset, do_record && !victim, $stable(e_occ_ff), "eviction without a victim")
   `RFD_ASSERT_NEXT(a_record_occupies, clock, reset, do_record && (cmd_ff == rfd_pkg::CMD_RECORD), h_occ_ff != '0, "recorded slot not occupied")
endmodule
`default_nettype wire

/* bench/request_fingerprint_dedup_table_tb.sv */
// ============================================================================
// Dedup table testbench
// Drives inspect, record, clear, resolve and undefined commands through the start/busy
// port, predicts each verdict and cached result, and checks every strobed
// response in order. The configuration is changed between idle phases.
// ============================================================================
module request_fingerprint_dedup_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 8;
   localparam int PoolSize = 12;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] request_id;
      logic [31:0] frame_id;
      logic [31:0] session_id;
      logic [31:0] payload_crc;
      logic [15:0] packet_index;
      logic [15:0] packet_count;
      logic [7:0]  message_type;
      logic [1:0]  logical_flags;
      logic [2:0]  entry_index;
      logic [7:0]  result_code;
      logic [7:0]  result_flags;
   } packet_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       has_entry;
      logic [2:0] found_index;
      logic       has_cached;
      logic [7:0] out_code;
      logic [7:0] out_flags;
   } answer_type;

   typedef struct {
      packet_type pkt;
      bit         typed;
      answer_type answer;
   } row_type;

   logic clock = 0, reset = 1, start = 0, busy, csr_write = 0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;
   packet_type req = '0;
   logic rsp_valid, rsp_has_entry, rsp_has_cached;
   logic [1:0] rsp_verdict;
   logic [2:0] rsp_found_index;
   logic [7:0] rsp_out_code, rsp_out_flags;

   request_fingerprint_dedup_table dut (
      .clock, .reset, .start, .busy, .csr_write, .csr_index, .csr_data,
      .req_command(req.command), .req_request_id(req.request_id),
      .req_frame_id(req.frame_id), .req_session_id(req.session_id),
      .req_payload_crc(req.payload_crc), .req_packet_index(req.packet_index),
      .req_packet_count(req.packet_count), .req_message_type(req.message_type),
      .req_logical_flags(req.logical_flags), .req_entry_index(req.entry_index),
      .req_result_code(req.result_code), .req_result_flags(req.result_flags),
      .rsp_valid, .rsp_verdict, .rsp_has_entry, .rsp_found_index,
      .rsp_has_cached, .rsp_out_code, .rsp_out_flags
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow of the table state and registers
   logic [7:0] busy_val, incomplete_val, retry_val, dup_val;
   packet_type hist [Depth];
   logic [7:0] cached_code [Depth];
   logic [7:0] cached_flags [Depth];
   bit         cached [Depth];
   bit         hist_used [Depth];
   logic [31:0] evicted_id [Depth];
   bit         evict_used [Depth];
   int         hist_ptr, evict_ptr;

   answer_type pending_answers [$];
   int errors = 0, results_seen = 0, items_sent = 0;
   int dup_hits = 0, conflict_hits = 0;

   function automatic void clear_table();
      for (int i = 0; i < Depth; i++) begin
         hist[i] = '0;
         cached_code[i] = '0;
         cached_flags[i] = '0;
         cached[i] = 0;
         hist_used[i] = 0;
         evicted_id[i] = '0;
         evict_used[i] = 0;
      end
      hist_ptr = 0;
      evict_ptr = 0;
   endfunction

   function automatic bit same_fingerprint(packet_type a, packet_type b);
      return a.frame_id == b.frame_id && a.session_id == b.session_id &&
         a.payload_crc == b.payload_crc && a.packet_index == b.packet_index &&
         a.packet_count == b.packet_count && a.message_type == b.message_type &&
         a.logical_flags == b.logical_flags;
   endfunction

   function automatic answer_type lookup_and_update(packet_type p);
      answer_type a;
      int slot;
      a = '0;
      case (p.command)
         rfd_pkg::CMD_INSPECT, rfd_pkg::CMD_RECORD: begin
            for (int i = 0; i < Depth; i++) begin
               if (hist_used[i] && hist[i].request_id == p.request_id) begin
                  a.verdict = same_fingerprint(hist[i], p) ? rfd_pkg::VERDICT_DUPLICATE
                                                           : rfd_pkg::VERDICT_CONFLICT;
                  a.has_entry = 1'b1;
                  a.found_index = 3'(i);
                  a.has_cached = cached[i];
                  a.out_code = cached[i] ? cached_code[i] : 8'd0;
                  a.out_flags = cached[i] ? cached_flags[i] : 8'd0;
                  return a;
               end
            end
            for (int i = 0; i < Depth; i++) begin
               if (evict_used[i] && evicted_id[i] == p.request_id) begin
                  a.verdict = rfd_pkg::VERDICT_CONFLICT;
                  return a;
               end
            end
            if (p.command == rfd_pkg::CMD_RECORD) begin
               slot = hist_ptr;
               if (hist_used[slot]) begin
                  evicted_id[evict_ptr] = hist[slot].request_id;
                  evict_used[evict_ptr] = 1;
                  evict_ptr = (evict_ptr + 1) % Depth;
               end
               hist[slot] = p;
               cached[slot] = 0;
               cached_code[slot] = '0;
               cached_flags[slot] = '0;
               hist_used[slot] = 1;
               hist_ptr = (slot + 1) % Depth;
               a.has_entry = 1'b1;
               a.found_index = 3'(slot);
            end
         end
         rfd_pkg::CMD_CLEAR: clear_table();
         rfd_pkg::CMD_RESOLVE, rfd_pkg::CMD_RESOLVE_DUP: begin
            slot = int'(p.entry_index);
            a.has_entry = 1'b1;
            a.found_index = p.entry_index;
            if (p.command == rfd_pkg::CMD_RESOLVE_DUP && cached[slot]) begin
               a.verdict = rfd_pkg::VERDICT_DUPLICATE;
               a.has_cached = 1'b1;
               a.out_code = cached_code[slot];
               a.out_flags = cached_flags[slot] | dup_val;
               return a;
            end
            if (!(p.result_code == busy_val || p.result_code == incomplete_val ||
                  (p.result_flags & retry_val) != 8'd0)) begin
               cached_code[slot] = p.result_code;
               cached_flags[slot] = p.result_flags;
               cached[slot] = 1;
            end
            a.has_cached = cached[slot];
            a.out_code = p.result_code;
            a.out_flags = p.result_flags;
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report_mismatch(string field, int want, int got);
      $display("ERROR t=%0t result %0d: %s expected %0h got %0h",
               $time, results_seen, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected response", 0, 1);
         end else begin
            w = pending_answers.pop_front();
            if (rsp_verdict !== w.verdict)
               report_mismatch("verdict", w.verdict, rsp_verdict);
            if (rsp_has_entry !== w.has_entry)
               report_mismatch("has_entry", w.has_entry, rsp_has_entry);
            if (rsp_found_index !== w.found_index)
               report_mismatch("found_index", w.found_index, rsp_found_index);
            if (rsp_has_cached !== w.has_cached)
               report_mismatch("has_cached", w.has_cached, rsp_has_cached);
            if (rsp_out_code !== w.out_code)
               report_mismatch("out_code", w.out_code, rsp_out_code);
            if (rsp_out_flags !== w.out_flags)
               report_mismatch("out_flags", w.out_flags, rsp_out_flags);
         end
         results_seen++;
      end
   end

   // one transfer; start stays high across back-to-back items
   task automatic issue(packet_type p, bit typed, answer_type typed_answer);
      answer_type a;
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      req <= p;
      start <= 1;
      do @(posedge clock); while (busy);
      a = lookup_and_update(p);
      if (a.verdict == rfd_pkg::VERDICT_DUPLICATE) dup_hits++;
      if (a.verdict == rfd_pkg::VERDICT_CONFLICT) conflict_hits++;
      pending_answers.push_back(typed ? typed_answer : a);
      items_sent++;
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending_answers.size() != 0 || busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         rfd_pkg::CSR_BUSY_CODE:       busy_val = val;
         rfd_pkg::CSR_INCOMPLETE_CODE: incomplete_val = val;
         rfd_pkg::CSR_RETRYABLE_MASK:  retry_val = val;
         default:                      dup_val = val;
      endcase
      @(posedge clock);
   endtask

   function automatic packet_type make_packet(logic [2:0] cmd, logic [31:0] rid,
                                              logic [31:0] fill, logic [2:0] idx,
                                              logic [7:0] code, logic [7:0] flg);
      packet_type p;
      p.command = cmd;
      p.request_id = rid;
      p.frame_id = fill;
      p.session_id = fill;
      p.payload_crc = fill;
      p.packet_index = fill[15:0];
      p.packet_count = fill[15:0];
      p.message_type = fill[7:0];
      p.logical_flags = fill[1:0];
      p.entry_index = idx;
      p.result_code = code;
      p.result_flags = flg;
      return p;
   endfunction

   function automatic packet_type random_fingerprint();
      packet_type p;
      p = '0;
      p.request_id = $urandom;
      p.frame_id = $urandom;
      p.session_id = $urandom;
      p.payload_crc = $urandom;
      p.packet_index = 16'($urandom);
      p.packet_count = 16'($urandom);
      p.message_type = 8'($urandom);
      p.logical_flags = 2'($urandom);
      return p;
   endfunction

   row_type directed [$];
   packet_type pool [PoolSize];

   task automatic add_row(packet_type p, bit typed, answer_type a);
      row_type r;
      r.pkt = p;
      r.typed = typed;
      r.answer = a;
      directed.push_back(r);
   endtask

   initial begin
      packet_type p;
      answer_type zero_ans, rec0;
      int pick, roll, phase;
      zero_ans = '0;
      rec0 = '0;
      rec0.has_entry = 1'b1;
      busy_val = '0; incomplete_val = '0; retry_val = '0; dup_val = '0;
      clear_table();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_csr(rfd_pkg::CSR_BUSY_CODE, 8'h10);
      write_csr(rfd_pkg::CSR_INCOMPLETE_CODE, 8'h11);
      write_csr(rfd_pkg::CSR_RETRYABLE_MASK, 8'h80);
      write_csr(rfd_pkg::CSR_DUPLICATE_MASK, 8'h40);

      add_row(make_packet(rfd_pkg::CMD_INSPECT, '0, '0, 3'd0, 8'h00, 8'h00), 1, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_RESOLVE_DUP, '0, '0, 3'd7, 8'h10, 8'h00), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_RECORD, '0, '0, 3'd0, 8'h00, 8'h00), 1, rec0);
      add_row(make_packet(rfd_pkg::CMD_RECORD, '1, '1, 3'd0, 8'h00, 8'h00), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_INSPECT, '1, '1, 3'd0, 8'h00, 8'h00), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_INSPECT, '1, 32'h5555_5555, 3'd0, 8'h00, 8'h00),
              0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_RESOLVE, '0, '0, 3'd1, 8'h11, 8'h00), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_RESOLVE, '0, '0, 3'd1, 8'h22, 8'h80), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_RESOLVE, '0, '0, 3'd1, 8'hFF, 8'h7F), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_RESOLVE_DUP, '0, '0, 3'd1, 8'h10, 8'hFF), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_INSPECT, '1, '1, 3'd0, 8'h00, 8'h00), 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_RESOLVE_DUP, '0, '0, 3'd3, 8'h00, 8'h00), 0, zero_ans);
      add_row(make_packet(3'd5, '1, '1, 3'd7, 8'hFF, 8'hFF), 1, zero_ans);
      add_row(make_packet(3'd6, '1, '1, 3'd7, 8'hFF, 8'hFF), 1, zero_ans);
      add_row(make_packet(3'd7, '1, '1, 3'd7, 8'hFF, 8'hFF), 1, zero_ans);
      for (int i = 0; i < 9; i++)
         add_row(make_packet(rfd_pkg::CMD_RECORD, 32'h100 + i, i, 3'd0, 8'h00, 8'h00),
                 0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_INSPECT, 32'h100, 32'd0, 3'd0, 8'h00, 8'h00),
              0, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_CLEAR, '1, '1, 3'd7, 8'hFF, 8'hFF), 1, zero_ans);
      add_row(make_packet(rfd_pkg::CMD_INSPECT, 32'h101, 32'd1, 3'd0, 8'h00, 8'h00),
              1, zero_ans);
      foreach (directed[i]) issue(directed[i].pkt, directed[i].typed, directed[i].answer);
      drain();

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_csr(rfd_pkg::CSR_BUSY_CODE, 8'h00);
               write_csr(rfd_pkg::CSR_INCOMPLETE_CODE, 8'h00);
               write_csr(rfd_pkg::CSR_RETRYABLE_MASK, 8'h00);
               write_csr(rfd_pkg::CSR_DUPLICATE_MASK, 8'h00);
            end
            1: begin
               write_csr(rfd_pkg::CSR_BUSY_CODE, 8'hFF);
               write_csr(rfd_pkg::CSR_INCOMPLETE_CODE, 8'hFE);
               write_csr(rfd_pkg::CSR_RETRYABLE_MASK, 8'hFF);
               write_csr(rfd_pkg::CSR_DUPLICATE_MASK, 8'hFF);
            end
            default: begin
               write_csr(rfd_pkg::CSR_BUSY_CODE, 8'($urandom));
               write_csr(rfd_pkg::CSR_INCOMPLETE_CODE, 8'($urandom));
               write_csr(rfd_pkg::CSR_RETRYABLE_MASK, 8'(8'h1 << $urandom_range(0, 7)));
               write_csr(rfd_pkg::CSR_DUPLICATE_MASK, 8'($urandom));
            end
         endcase
         foreach (pool[i]) pool[i] = random_fingerprint();
         pool[0].request_id = '0;
         pool[1].request_id = '1;
         for (int n = 0; n < 200; n++) begin
            pick = $urandom_range(0, PoolSize - 1);
            p = pool[pick];
            roll = $urandom_range(0, 99);
            // mostly exact repeats, some altered fingerprints of a known id
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 6))
                  0: p.frame_id = $urandom;
                  1: p.session_id = $urandom;
                  2: p.payload_crc = $urandom;
                  3: p.packet_index = 16'($urandom);
                  4: p.packet_count = 16'($urandom);
                  5: p.message_type = 8'($urandom);
                  default: p.logical_flags = 2'($urandom);
               endcase
            end
            if (roll < 35) p.command = rfd_pkg::CMD_RECORD;
            else if (roll < 58) p.command = rfd_pkg::CMD_INSPECT;
            else if (roll < 76) p.command = rfd_pkg::CMD_RESOLVE;
            else if (roll < 94) p.command = rfd_pkg::CMD_RESOLVE_DUP;
            else if (roll < 97) p.command = rfd_pkg::CMD_CLEAR;
            else p.command = 3'($urandom_range(5, 7));
            p.entry_index = 3'($urandom);
            case ($urandom_range(0, 3))
               0: p.result_code = busy_val;
               1: p.result_code = incomplete_val;
               default: p.result_code = 8'($urandom);
            endcase
            p.result_flags = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                         : 8'($urandom) & ~retry_val;
            issue(p, 0, zero_ans);
         end
         drain();
      end

      $display("Covered %0d commands, %0d responses, %0d duplicate and %0d conflict verdicts",
               items_sent, results_seen, dup_hits, conflict_hits);
      $display("over six register settings including all-zero and all-one extremes");
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ERROR timeout with %0d responses outstanding", pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl
rtl/rfd_pkg.sv
rtl/rfd_ctrl.sv
rtl/rfd_datapath.sv
rtl/request_fingerprint_dedup_table.sv
bench/request_fingerprint_dedup_table_tb.sv
